>>> rtl/core/rcbr_pkg.sv
// Package for the crop and bilinear resize block: sizes, codes and small helpers.
// Used by roi_crop_bilinear_resize; depends on nothing.
package rcbr_pkg;

    localparam int MAX_WIDTH   = 320;
    localparam int MAX_HEIGHT  = 240;
    localparam int OUT_SIZE    = 192;
    localparam int FRAC_BITS   = 8;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // floor(m / 3) = (m * RECIP3) >> RECIP3_SH for m below 2^22.
    localparam int RECIP3_SH = 23;
    localparam logic [21:0] RECIP3 = 22'd2796203;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_BOX    = 2'd1,
        REQ_SAMPLE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_BOX,
        KIND_SAMPLE
    } t_kind;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_PAD    = 2'd2,
        REG_SPARE  = 2'd3
    } t_reg;

    localparam logic RES_BOX   = 1'b0;
    localparam logic RES_PIXEL = 1'b1;

    function automatic logic [19:0] sat20(input logic signed [20:0] v);
        logic [19:0] r;
        begin
            if (v > 21'sd524287) r = 20'h7FFFF;
            else if (v < -21'sd524288) r = 20'h80000;
            else r = v[19:0];
            return r;
        end
    endfunction

endpackage

>>> rtl/core/roi_crop_bilinear_resize.sv
// Crop and bilinear resize with a built-in RGB frame store, as one pipeline.
// Depends on rcbr_pkg for sizes, request codes and the saturation helper.
//
// Usage: items enter on the s_axis channel (tuser carries the request type) and
// results leave on m_axis (tuser carries the result kind). Pixel writes fill the
// frame store and give no result; a set-box item gives a corner report and
// updates the crop; a sample item gives one interpolated crop pixel.
// Writes and samples go at one item per cycle unless the output stalls or a box
// is pending; the frame store is held twice, each copy with one write
// and two reads per cycle, so the four neighbors are read in the same cycle.
// A set-box item holds further input after its own transfer, until its crop
// values are committed in stage five.
// Reset clears the pipeline, the crop and the registers (width 320, height
// 240, pad 0); the frame store is not cleared and must be written before read.
// When the receiver stalls, the finished result waits in the output register
// and the pipeline keeps moving until a second result reaches the last stage.
// The user must write registers over the APB port only while the block is idle; not enforced.
module roi_crop_bilinear_resize
    import rcbr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // pixel_index, pixel_rgb, face_x, face_y, face_w, face_h, out_col, out_row
    input  logic [127:0]  s_axis_tdata,
    // req_type
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // box_left, box_top, box_right, box_bottom, red, green, blue
    output logic [103:0]  m_axis_tdata,
    // result_kind
    output logic [0:0]    m_axis_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    // Configuration
    logic [8:0] r_frame_width;
    logic [7:0] r_frame_height;
    logic [7:0] r_pad_frac;
    logic [8:0] c_w;
    logic [7:0] c_h;
    t_reg       c_reg;

    assign c_reg  = t_reg'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 9'd320;
            r_frame_height <= 8'd240;
            r_pad_frac     <= 8'd0;
        end else if (psel && penable && pwrite && pready) begin
            case (c_reg)
                REG_WIDTH:  r_frame_width  <= pwdata[8:0];
                REG_HEIGHT: r_frame_height <= pwdata[7:0];
                REG_PAD:    r_pad_frac     <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (c_reg)
            REG_WIDTH:  prdata = {23'd0, r_frame_width};
            REG_HEIGHT: prdata = {24'd0, r_frame_height};
            REG_PAD:    prdata = {24'd0, r_pad_frac};
            default:    prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_frame_width == 9'd0) c_w = 9'd1;
        else if (r_frame_width > 9'(MAX_WIDTH)) c_w = 9'(MAX_WIDTH);
        else c_w = r_frame_width;
        if (r_frame_height == 8'd0) c_h = 8'd1;
        else if (r_frame_height > 8'(MAX_HEIGHT)) c_h = 8'(MAX_HEIGHT);
        else c_h = r_frame_height;
    end

    logic [16:0] c_lim_x;
    logic [15:0] c_lim_y;
    assign c_lim_x = {c_w - 9'd1, 8'd0};
    assign c_lim_y = {c_h - 8'd1, 8'd0};

    // Input fields
    logic [16:0] in_idx;
    logic [23:0] in_rgb;
    logic [15:0] in_fx, in_fy, in_fw, in_fh;
    logic [7:0]  in_col, in_row;
    t_req        in_req;

    assign in_idx = s_axis_tdata[16:0];
    assign in_rgb = s_axis_tdata[40:17];
    assign in_fx  = s_axis_tdata[56:41];
    assign in_fy  = s_axis_tdata[72:57];
    assign in_fw  = s_axis_tdata[88:73];
    assign in_fh  = s_axis_tdata[104:89];
    assign in_col = s_axis_tdata[112:105];
    assign in_row = s_axis_tdata[120:113];
    assign in_req = t_req'(s_axis_tuser);

    // Crop state
    logic [19:0] r_crop_left, r_crop_top, r_crop_side;

    // Pipeline control
    logic  r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    t_kind r_k1, r_k2, r_k3, r_k4, r_k5, r_k6, r_k7;
    logic  r_o_valid;
    logic  c_r7_out, c_o_load, c_en, c_box_pend, c_acc;

    assign c_r7_out   = r_v7 && (r_k7 != KIND_WRITE);
    assign c_o_load   = !r_o_valid || m_axis_tready;
    assign c_en       = c_o_load || !c_r7_out;
    assign c_box_pend = (r_v1 && r_k1 == KIND_BOX) || (r_v2 && r_k2 == KIND_BOX)
                     || (r_v3 && r_k3 == KIND_BOX) || (r_v4 && r_k4 == KIND_BOX);
    assign s_axis_tready = c_en && !c_box_pend;
    assign c_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0;
        end else if (c_en) begin
            r_v1 <= c_acc && (in_req != REQ_NONE);
            r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
            r_v5 <= r_v4; r_v6 <= r_v5; r_v7 <= r_v6;
        end
    end

    // Stage 1: scale the box to pixels; sample offsets times the side.
    logic [16:0] r1_idx;
    logic        r1_ok;
    logic [23:0] r1_rgb;
    logic [17:0] r1_xa, r1_xb, r1_ya, r1_yb;
    logic [27:0] r1_px, r1_py;
    logic [19:0] r1_sl, r1_st;
    logic [18:0] c_side;
    logic [25:0] c_xa, c_xb, c_ya, c_yb;
    t_kind       c_k0;

    always_comb begin
        c_side = (r_crop_side < 20'd256) ? 19'd256 : r_crop_side[18:0];
        c_xa = 26'(in_fx) * 26'(c_w);
        c_xb = 26'(17'(in_fx) + 17'(in_fw)) * 26'(c_w);
        c_ya = 26'(in_fy) * 26'(c_h);
        c_yb = 26'(17'(in_fy) + 17'(in_fh)) * 26'(c_h);
        case (in_req)
            REQ_WRITE: c_k0 = KIND_WRITE;
            REQ_BOX:   c_k0 = KIND_BOX;
            default:   c_k0 = KIND_SAMPLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_k1   <= c_k0;
            r1_idx <= in_idx;
            r1_ok  <= (in_idx < 17'(STORE_DEPTH));
            r1_rgb <= in_rgb;
            r1_xa  <= c_xa[25:8];
            r1_xb  <= c_xb[25:8];
            r1_ya  <= c_ya[25:8];
            r1_yb  <= c_yb[25:8];
            r1_px  <= 28'({in_col, 1'b1}) * 28'(c_side);
            r1_py  <= 28'({in_row, 1'b1}) * 28'(c_side);
            r1_sl  <= r_crop_left;
            r1_st  <= r_crop_top;
        end
    end

    // Stage 2: padding; divide the sample offsets by twice the output size.
    logic [16:0] r2_idx;
    logic        r2_ok;
    logic [23:0] r2_rgb;
    logic [17:0] r2_xa, r2_xb, r2_ya, r2_yb, r2_padx, r2_pady;
    logic [19:0] r2_qx, r2_qy, r2_sl, r2_st;
    logic [17:0] c_szx, c_szy;
    logic [25:0] c_pdx, c_pdy;
    logic [42:0] c_qx, c_qy;

    always_comb begin
        c_szx = r1_xb - r1_xa;
        c_szy = r1_yb - r1_ya;
        if (c_szx < 18'd256) c_szx = 18'd256;
        if (c_szy < 18'd256) c_szy = 18'd256;
        c_pdx = 26'(c_szx) * 26'(r_pad_frac);
        c_pdy = 26'(c_szy) * 26'(r_pad_frac);
        c_qx  = 43'(r1_px[27:7]) * 43'(RECIP3);
        c_qy  = 43'(r1_py[27:7]) * 43'(RECIP3);
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_k2    <= r_k1;
            r2_idx  <= r1_idx;
            r2_ok   <= r1_ok;
            r2_rgb  <= r1_rgb;
            r2_xa   <= r1_xa;
            r2_xb   <= r1_xb;
            r2_ya   <= r1_ya;
            r2_yb   <= r1_yb;
            r2_padx <= c_pdx[25:8];
            r2_pady <= c_pdy[25:8];
            r2_qx   <= c_qx[RECIP3_SH +: 20];
            r2_qy   <= c_qy[RECIP3_SH +: 20];
            r2_sl   <= r1_sl;
            r2_st   <= r1_st;
        end
    end

    // Stage 3: clamp the box edges; sample position clamped to the frame.
    logic [16:0] r3_idx;
    logic        r3_ok;
    logic [23:0] r3_rgb;
    logic [17:0] r3_x1, r3_x2, r3_y1, r3_y2;
    logic [8:0]  r3_x0;
    logic [7:0]  r3_y0, r3_ax, r3_ay;
    logic        r3_dx, r3_dy;
    logic signed [18:0] c_lox, c_loy;
    logic [18:0] c_hix, c_hiy;
    logic signed [21:0] c_ppx, c_ppy;
    logic [16:0] c_cpx;
    logic [15:0] c_cpy;

    always_comb begin
        c_lox = $signed({1'b0, r2_xa}) - $signed({1'b0, r2_padx});
        c_loy = $signed({1'b0, r2_ya}) - $signed({1'b0, r2_pady});
        c_hix = 19'(r2_xb) + 19'(r2_padx);
        c_hiy = 19'(r2_yb) + 19'(r2_pady);
        c_ppx = $signed({{2{r2_sl[19]}}, r2_sl}) + $signed({2'b0, r2_qx}) - 22'sd128;
        c_ppy = $signed({{2{r2_st[19]}}, r2_st}) + $signed({2'b0, r2_qy}) - 22'sd128;
        if (c_ppx < 0) c_cpx = 17'd0;
        else if (c_ppx > $signed(22'(c_lim_x))) c_cpx = c_lim_x;
        else c_cpx = c_ppx[16:0];
        if (c_ppy < 0) c_cpy = 16'd0;
        else if (c_ppy > $signed(22'(c_lim_y))) c_cpy = c_lim_y;
        else c_cpy = c_ppy[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_k3   <= r_k2;
            r3_idx <= r2_idx;
            r3_ok  <= r2_ok;
            r3_rgb <= r2_rgb;
            r3_x1  <= (c_lox < 0) ? 18'd0 : c_lox[17:0];
            r3_y1  <= (c_loy < 0) ? 18'd0 : c_loy[17:0];
            r3_x2  <= (c_hix > 19'(c_lim_x)) ? 18'(c_lim_x) : c_hix[17:0];
            r3_y2  <= (c_hiy > 19'(c_lim_y)) ? 18'(c_lim_y) : c_hiy[17:0];
            r3_x0  <= c_cpx[16:8];
            r3_ax  <= c_cpx[7:0];
            r3_y0  <= c_cpy[15:8];
            r3_ay  <= c_cpy[7:0];
            r3_dx  <= (10'(c_cpx[16:8]) + 10'd1) < 10'(c_w);
            r3_dy  <= (9'(c_cpy[15:8]) + 9'd1) < 9'(c_h);
        end
    end

    // Stage 4: square side and centers; frame store addresses.
    logic [ADDR_W-1:0] r4_a00, r4_a01;
    logic        r4_we, r4_dx;
    logic [23:0] r4_rgb;
    logic [7:0]  r4_ax, r4_ay;
    logic signed [19:0] r4_side;
    logic [18:0] r4_sx, r4_sy;
    logic signed [19:0] c_spx, c_spy;

    always_comb begin
        c_spx = $signed({2'b0, r3_x2}) - $signed({2'b0, r3_x1});
        c_spy = $signed({2'b0, r3_y2}) - $signed({2'b0, r3_y1});
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_k4    <= r_k3;
            r4_we   <= r_v3 && (r_k3 == KIND_WRITE) && r3_ok;
            r4_rgb  <= r3_rgb;
            r4_dx   <= r3_dx;
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
            if (r_k3 == KIND_WRITE) begin
                r4_a00 <= r3_idx;
            end else begin
                r4_a00 <= ADDR_W'(17'(r3_y0) * 17'(c_w) + 17'(r3_x0));
            end
            r4_a01  <= ADDR_W'(17'(9'(r3_y0) + 9'(r3_dy)) * 17'(c_w) + 17'(r3_x0));
            r4_side <= (c_spy > c_spx) ? c_spy : c_spx;
            r4_sx   <= 19'(r3_x1) + 19'(r3_x2);
            r4_sy   <= 19'(r3_y1) + 19'(r3_y2);
        end
    end

    // Stage 5: frame store access; box corners and crop commit.
    logic [23:0] r_mem_a [0:STORE_DEPTH-1];
    logic [23:0] r_mem_b [0:STORE_DEPTH-1];
    logic [23:0] r5_p00, r5_p10, r5_p01, r5_p11;
    logic [7:0]  r5_ax, r5_ay;
    logic [19:0] r5_bl, r5_bt, r5_br, r5_bb;
    logic signed [20:0] c_l, c_r, c_t, c_b, c_cs;

    always_comb begin
        c_l  = ($signed({2'b0, r4_sx}) - $signed({r4_side[19], r4_side})) >>> 1;
        c_r  = ($signed({2'b0, r4_sx}) + $signed({r4_side[19], r4_side})) >>> 1;
        c_t  = ($signed({2'b0, r4_sy}) - $signed({r4_side[19], r4_side})) >>> 1;
        c_b  = ($signed({2'b0, r4_sy}) + $signed({r4_side[19], r4_side})) >>> 1;
        c_cs = (r4_side < 20'sd256) ? 21'sd256 : $signed({r4_side[19], r4_side});
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            if (r4_we) begin
                r_mem_a[r4_a00] <= r4_rgb;
                r_mem_b[r4_a00] <= r4_rgb;
            end
            r5_p00 <= r_mem_a[r4_a00];
            r5_p10 <= r_mem_a[ADDR_W'(r4_a00 + ADDR_W'(r4_dx))];
            r5_p01 <= r_mem_b[r4_a01];
            r5_p11 <= r_mem_b[ADDR_W'(r4_a01 + ADDR_W'(r4_dx))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_k5  <= r_k4;
            r5_ax <= r4_ax;
            r5_ay <= r4_ay;
            r5_bl <= sat20(c_l);
            r5_bt <= sat20(c_t);
            r5_br <= sat20(c_r);
            r5_bb <= sat20(c_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crop_left <= 20'd0;
            r_crop_top  <= 20'd0;
            r_crop_side <= 20'd0;
        end else if (c_en && r_v4 && r_k4 == KIND_BOX) begin
            r_crop_left <= sat20(c_l);
            r_crop_top  <= sat20(c_t);
            r_crop_side <= sat20(c_cs);
        end
    end

    // Stage 6: horizontal blend of each channel.
    logic [15:0] r6_h0 [0:2];
    logic [15:0] r6_h1 [0:2];
    logic [7:0]  r6_ay;
    logic [19:0] r6_bl, r6_bt, r6_br, r6_bb;
    logic [8:0]  c_iax;

    assign c_iax = 9'd256 - 9'(r5_ax);

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_k6  <= r_k5;
            r6_ay <= r5_ay;
            r6_bl <= r5_bl;
            r6_bt <= r5_bt;
            r6_br <= r5_br;
            r6_bb <= r5_bb;
            for (int j = 0; j < 3; j++) begin
                r6_h0[j] <= 16'(17'(r5_p00[8*j +: 8]) * 17'(c_iax)
                              + 17'(r5_p10[8*j +: 8]) * 17'(r5_ax));
                r6_h1[j] <= 16'(17'(r5_p01[8*j +: 8]) * 17'(c_iax)
                              + 17'(r5_p11[8*j +: 8]) * 17'(r5_ax));
            end
        end
    end

    // Stage 7: vertical blend and rounding half up.
    logic [7:0]  r7_ch [0:2];
    logic [19:0] r7_bl, r7_bt, r7_br, r7_bb;
    logic [8:0]  c_iay;
    logic [24:0] c_vv [0:2];

    assign c_iay = 9'd256 - 9'(r6_ay);

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c_vv[j] = 25'(r6_h0[j]) * 25'(c_iay) + 25'(r6_h1[j]) * 25'(r6_ay)
                    + 25'd32768;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_k7  <= r_k6;
            r7_bl <= r6_bl;
            r7_bt <= r6_bt;
            r7_br <= r6_br;
            r7_bb <= r6_bb;
            for (int j = 0; j < 3; j++) begin
                r7_ch[j] <= (c_vv[j][24:16] > 9'd255) ? 8'd255 : c_vv[j][23:16];
            end
        end
    end

    // Output register
    logic         r_o_kind;
    logic [103:0] r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (c_o_load) begin
            r_o_valid <= c_r7_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_o_load && c_r7_out) begin
            if (r_k7 == KIND_BOX) begin
                r_o_kind <= RES_BOX;
                r_o_data <= {24'd0, r7_bb, r7_br, r7_bt, r7_bl};
            end else begin
                r_o_kind <= RES_PIXEL;
                r_o_data <= {r7_ch[2], r7_ch[1], r7_ch[0], 80'd0};
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_kind;

    // A sample never trails a box that has not yet committed its crop.
    a_no_stale_crop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_k1 == KIND_SAMPLE) |-> !((r_v2 && r_k2 == KIND_BOX)
            || (r_v3 && r_k3 == KIND_BOX) || (r_v4 && r_k4 == KIND_BOX)))
        else $error("sample entered behind an uncommitted box");

    // After a box commits, the crop side is at least one pixel.
    a_side_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_en && r_v4 && r_k4 == KIND_BOX) |=> (r_crop_side >= 20'd256))
        else $error("crop side below one pixel");

    // A pending result is never overwritten while the pipeline moves.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !m_axis_tready && c_en) |-> !c_r7_out)
        else $error("pipeline advanced over a stalled result");

    // Neighbor reads stay inside the frame store.
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_k4 == KIND_SAMPLE) |->
            (18'(r4_a01) + 18'(r4_dx) < 18'(STORE_DEPTH)))
        else $error("frame store read out of range");

endmodule
